// ===== sv/hesq_pkg.sv =====
// ----------------------------------------------------------------------------
// hesq_pkg
// Types and fixed constants shared by the hit error squared parameterization.
// ----------------------------------------------------------------------------
package hesq_pkg;

	typedef struct packed {
		logic signed [15:0] z_pos;
		logic signed [15:0] crossing_angle;
		logic signed [15:0] dip_tangent;
	} hesq_in_t;

	typedef struct packed {
		logic [30:0] cross_error_sq;
		logic [30:0] dip_error_sq;
		logic [1:0]  cross_clamp;
		logic [1:0]  dip_clamp;
	} hesq_out_t;

	// clamp codes
	localparam logic [1:0] CLAMP_NONE = 2'd0;
	localparam logic [1:0] CLAMP_MIN  = 2'd1;
	localparam logic [1:0] CLAMP_MAX  = 2'd2;

	// register indexes
	localparam int         REG_IDX_W            = 3;
	localparam logic [2:0] REG_CROSS_BASE       = 3'd0;
	localparam logic [2:0] REG_CROSS_DRIFT_GAIN = 3'd1;
	localparam logic [2:0] REG_CROSS_ANGLE_GAIN = 3'd2;
	localparam logic [2:0] REG_DIP_BASE         = 3'd3;
	localparam logic [2:0] REG_DIP_DRIFT_GAIN   = 3'd4;
	localparam logic [2:0] REG_DIP_ANGLE_GAIN   = 3'd5;

	// divider geometry
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 34;
	localparam int DIV_QUO_W = 46;

	localparam logic signed [32:0] CORDIC_K  = 33'sd652032874;
	localparam logic signed [32:0] COS_FLOOR = 33'sd10737418;
	localparam logic [33:0]        C2_MIN    = 34'd107374;
	localparam logic [44:0]        FACTOR_MAX = {45{1'b1}};

	localparam logic [29:0] ATAN_TAB [24] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10680862, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
	};

endpackage

// ===== sv/hesq_div.sv =====
// ----------------------------------------------------------------------------
// hesq_div
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module hesq_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic [hesq_pkg::DIV_NUM_W-1:0]  num,
	input  logic [hesq_pkg::DIV_DEN_W-1:0]  den,
	output logic [hesq_pkg::DIV_QUO_W-1:0]  quo
);
	localparam int NW = hesq_pkg::DIV_NUM_W;
	localparam int DW = hesq_pkg::DIV_DEN_W;
	localparam int QW = hesq_pkg::DIV_QUO_W;
	localparam int CW = DW + QW;

	logic [NW-1:0] rem_s [1:QW];
	logic [DW-1:0] den_s [1:QW];
	logic [QW-1:0] quo_s [1:QW];

	for (genvar j = 1; j <= QW; j++) begin : g_stage
		localparam int B = QW - j;
		logic [NW-1:0] rem_p;
		logic [DW-1:0] den_p;
		logic [QW-1:0] quo_p;
		logic [CW-1:0] trial;
		logic          take;

		if (j == 1) begin : g_first
			assign rem_p = num;
			assign den_p = den;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_s[j-1];
			assign den_p = den_s[j-1];
			assign quo_p = quo_s[j-1];
		end

		assign trial = {{QW{1'b0}}, den_p} << B;
		assign take  = {{(CW-NW){1'b0}}, rem_p} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= take ? (rem_p - trial[NW-1:0]) : rem_p;
				den_s[j] <= den_p;
				quo_s[j] <= quo_p | ({{(QW-1){1'b0}}, take} << B);
			end
		end
	end

	assign quo = quo_s[QW];

	// mark the cycles after reset release for the checks below
	logic rst_seen_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_seen_q <= 1'b0;
		end else begin
			rst_seen_q <= 1'b1;
		end
	end

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rst_seen_q && en && (den != '0) |=> (den_s[1] != '0))
		else $error("divider lost its divisor");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rst_seen_q && $past(en) && !$isunknown({rem_s[QW], den_s[QW]})
		|-> ({{(CW-NW){1'b0}}, rem_s[QW]} < {{QW{1'b0}}, den_s[QW]})
		|| (den_s[QW] == '0))
		else $error("divider remainder not below divisor");
	a_quo_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(quo))
		else $error("divider output moved while held");
endmodule

// ===== sv/hit_error_squared_param.sv =====
// ----------------------------------------------------------------------------
// hit_error_squared_param
// Squared cross and dip errors of one detector hit from six coefficients.
// ----------------------------------------------------------------------------
// Use:
//   Input channel in_valid / in_stall / in_data carries one hit per request
//   (z position, crossing angle, dip tangent). Output channel out_valid /
//   out_stall / out_data carries one result per hit, in order: both squared
//   errors and their clamp codes. Coefficients are written through cfg_we,
//   cfg_index and cfg_data, only while no hit is in flight; this binds the user,
//   the block does not enforce it. Throughput is one hit per cycle unless
//   out_stall holds the output. The pipeline is one input stage, one CORDIC
//   micro-rotation per stage (the drift term is formed alongside), two
//   squaring stages, 46 divider stages (one quotient bit each), three
//   multiply and sum stages and the output register.
//   Reset clears all valid bits and the coefficients to zero.
//   The whole pipeline advances together: while out_valid is held by
//   out_stall, every stage holds and in_stall is raised, so nothing is lost
//   or repeated; bubbles move on whenever the output is free.
// ----------------------------------------------------------------------------
module hit_error_squared_param #(
	parameter int ANGLE_BITS    = 16,
	parameter int ERR_FRAC_BITS = 30
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  hesq_pkg::hesq_in_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output hesq_pkg::hesq_out_t               out_data,
	input  logic                              cfg_we,
	input  logic [hesq_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);
	localparam int NIT = (ANGLE_BITS < 24) ? ANGLE_BITS : 24;
	localparam int QW  = hesq_pkg::DIV_QUO_W;
	localparam logic signed [48:0] ERR_MAX = 49'sd1 <<< ERR_FRAC_BITS;
	localparam logic signed [48:0] ERR_MIN = (ERR_MAX + 49'sd500000) / 49'sd1000000;
	localparam logic signed [33:0] ANG_QTR  = 34'sd1073741824;
	localparam logic signed [33:0] ANG_HALF = 34'sd2147483648;
	localparam logic [2:0] LANE_COEF [4] = '{
		hesq_pkg::REG_CROSS_DRIFT_GAIN, hesq_pkg::REG_CROSS_ANGLE_GAIN,
		hesq_pkg::REG_DIP_DRIFT_GAIN, hesq_pkg::REG_DIP_ANGLE_GAIN
	};

	logic en;
	logic out_valid_q;
	hesq_pkg::hesq_out_t out_data_q;

	assign en        = !out_valid_q || !out_stall;
	assign in_stall  = !en;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ------------------------------------------------------------ coefficients
	logic [31:0] cf_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) cf_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hesq_pkg::REG_CROSS_BASE:       cf_q[hesq_pkg::REG_CROSS_BASE] <= cfg_data;
				hesq_pkg::REG_CROSS_DRIFT_GAIN: cf_q[hesq_pkg::REG_CROSS_DRIFT_GAIN] <= cfg_data;
				hesq_pkg::REG_CROSS_ANGLE_GAIN: cf_q[hesq_pkg::REG_CROSS_ANGLE_GAIN] <= cfg_data;
				hesq_pkg::REG_DIP_BASE:         cf_q[hesq_pkg::REG_DIP_BASE] <= cfg_data;
				hesq_pkg::REG_DIP_DRIFT_GAIN:   cf_q[hesq_pkg::REG_DIP_DRIFT_GAIN] <= cfg_data;
				hesq_pkg::REG_DIP_ANGLE_GAIN:   cf_q[hesq_pkg::REG_DIP_ANGLE_GAIN] <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ input stage
	logic [16:0]        az;
	logic signed [17:0] nv;
	logic [17:0]        nneg;
	logic signed [33:0] ang_raw;
	logic signed [33:0] ang_in;
	logic               flip_in;
	logic [15:0]        ta;

	always_comb begin
		az = in_data.z_pos[15] ? (17'd0 - {1'b1, in_data.z_pos}) : {1'b0, in_data.z_pos};
		nv = 18'sd20000 - $signed({1'b0, az});
		nneg = 18'd0 - nv;
		ang_raw = {{2{in_data.crossing_angle[15]}}, in_data.crossing_angle, 16'd0};
		flip_in = 1'b0;
		ang_in = ang_raw;
		// fold into the right half plane
		if (ang_raw > ANG_QTR) begin
			ang_in = ang_raw - ANG_HALF;
			flip_in = 1'b1;
		end else if (ang_raw < -ANG_QTR) begin
			ang_in = ang_raw + ANG_HALF;
			flip_in = 1'b1;
		end
		ta = in_data.dip_tangent[15] ? (16'd0 - in_data.dip_tangent) : in_data.dip_tangent;
	end

	logic               v_s1;
	logic [14:0]        m_s1;
	logic               neg_s1;
	logic [15:0]        ta_s1;
	logic               flip_s1;
	logic signed [33:0] ang_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1    <= nv[17] ? nneg[14:0] : nv[14:0];
			neg_s1  <= nv[17];
			ta_s1   <= ta;
			flip_s1 <= flip_in;
			ang_s1  <= ang_in;
		end
	end

	// ------------------------------------------------------------ CORDIC and drift
	logic               vc_s  [1:NIT];
	logic               fl_s  [1:NIT];
	logic signed [32:0] cx_s  [1:NIT];
	logic signed [32:0] cy_s  [1:NIT];
	logic signed [33:0] ca_s  [1:NIT];
	logic [30:0]        tsq_s [1:NIT];
	logic signed [32:0] dz_s  [3:NIT];
	logic [31:0]        p1_s2;
	logic [21:0]        x114_s2;
	logic               neg_s2;
	logic [44:0]        tq_s3;
	logic [31:0]        p1_s3;
	logic               neg_s3;

	for (genvar k = 1; k <= NIT; k++) begin : g_cordic
		logic               pv;
		logic               pf;
		logic signed [32:0] px;
		logic signed [32:0] py;
		logic signed [33:0] pa;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [33:0] at;

		if (k == 1) begin : g_first
			assign pv = v_s1;
			assign pf = flip_s1;
			assign px = hesq_pkg::CORDIC_K;
			assign py = '0;
			assign pa = ang_s1;
		end else begin : g_next
			assign pv = vc_s[k-1];
			assign pf = fl_s[k-1];
			assign px = cx_s[k-1];
			assign py = cy_s[k-1];
			assign pa = ca_s[k-1];
		end

		assign dx = py >>> (k - 1);
		assign dy = px >>> (k - 1);
		assign at = $signed({4'd0, hesq_pkg::ATAN_TAB[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vc_s[k] <= 1'b0;
			end else if (en) begin
				vc_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				fl_s[k] <= pf;
				if (pa >= 0) begin
					cx_s[k] <= px - dx;
					cy_s[k] <= py + dy;
					ca_s[k] <= pa - at;
				end else begin
					cx_s[k] <= px + dx;
					cy_s[k] <= py - dy;
					ca_s[k] <= pa + at;
				end
			end
		end

		// drift dz = n * 2^30 / 10000 = 107374 n + floor(114 n / 625)
		if (k == 1) begin : g_dz1
			always_ff @(posedge clk) begin
				if (en) begin
					p1_s2    <= 32'(m_s1) * 32'd107374;
					x114_s2  <= 22'(m_s1) * 22'd114;
					neg_s2   <= neg_s1;
					tsq_s[k] <= 31'(ta_s1) * 31'(ta_s1);
				end
			end
		end else if (k == 2) begin : g_dz2
			always_ff @(posedge clk) begin
				if (en) begin
					tq_s3    <= 45'(x114_s2) * 45'd6871948;
					p1_s3    <= p1_s2;
					neg_s3   <= neg_s2;
					tsq_s[k] <= tsq_s[k-1];
				end
			end
		end else if (k == 3) begin : g_dz3
			logic [32:0] dsum;
			assign dsum = {1'b0, p1_s3} + {20'd0, tq_s3[44:32]};
			always_ff @(posedge clk) begin
				if (en) begin
					dz_s[k]  <= neg_s3 ? -$signed(dsum) : $signed(dsum);
					tsq_s[k] <= tsq_s[k-1];
				end
			end
		end else begin : g_dzn
			always_ff @(posedge clk) begin
				if (en) begin
					dz_s[k]  <= dz_s[k-1];
					tsq_s[k] <= tsq_s[k-1];
				end
			end
		end
	end

	// ------------------------------------------------------------ cos/sin and dip terms
	logic signed [32:0] xf;
	logic signed [32:0] yf;
	logic signed [32:0] yneg;

	assign xf   = fl_s[NIT] ? -cx_s[NIT] : cx_s[NIT];
	assign yf   = fl_s[NIT] ? -cy_s[NIT] : cy_s[NIT];
	assign yneg = -yf;

	logic               v_s5;
	logic [31:0]        cos_s5;
	logic [31:0]        sinm_s5;
	logic signed [63:0] dtt_s5;
	logic signed [32:0] dz_s5;
	logic [36:0]        d2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= vc_s[NIT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// floor cos at 0.01, this also catches negative cos
			cos_s5  <= (xf < hesq_pkg::COS_FLOOR) ? hesq_pkg::COS_FLOOR[31:0] : xf[31:0];
			sinm_s5 <= yf[32] ? yneg[31:0] : yf[31:0];
			dtt_s5  <= 64'(dz_s[NIT]) * 64'($signed({2'b00, tsq_s[NIT]}));
			dz_s5   <= dz_s[NIT];
			d2_s5   <= {tsq_s[NIT], 6'd0};
		end
	end

	logic [63:0]        c2_full;
	logic [63:0]        s2_full;
	logic signed [63:0] dtt_bias;
	logic signed [63:0] dtt_q;
	logic signed [32:0] dzneg;

	assign c2_full  = 64'(cos_s5) * 64'(cos_s5);
	assign s2_full  = 64'(sinm_s5) * 64'(sinm_s5);
	// round toward zero on the 2^24 scale
	assign dtt_bias = dtt_s5[63] ? (dtt_s5 + 64'sd16777215) : dtt_s5;
	assign dtt_q    = dtt_bias >>> 24;
	assign dzneg    = -dz_s5;

	logic               v_s6;
	logic [33:0]        c2_s6;
	logic [33:0]        s2_s6;
	logic [63:0]        num1_s6;
	logic               gneg_s6;
	logic signed [47:0] d1_s6;
	logic [36:0]        d2_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c2_s6   <= c2_full[63:30];
			s2_s6   <= s2_full[63:30];
			num1_s6 <= {2'b00, (dz_s5[32] ? dzneg[31:0] : dz_s5[31:0]), 30'd0};
			gneg_s6 <= dz_s5[32];
			d1_s6   <= 48'(dz_s5) + 48'(dtt_q);
			d2_s6   <= d2_s5;
		end
	end

	// ------------------------------------------------------------ dividers
	logic [QW-1:0] q1;
	logic [QW-1:0] q2;

	hesq_div u_div_drift (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.num    (num1_s6),
		.den    (c2_s6),
		.quo    (q1)
	);

	hesq_div u_div_angle (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.num    ({s2_s6, 30'd0}),
		.den    (c2_s6),
		.quo    (q2)
	);

	logic               vd_s  [1:QW];
	logic               gnd_s [1:QW];
	logic signed [47:0] d1d_s [1:QW];
	logic [36:0]        d2d_s [1:QW];

	for (genvar j = 1; j <= QW; j++) begin : g_side
		if (j == 1) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vd_s[j] <= 1'b0;
				end else if (en) begin
					vd_s[j] <= v_s6;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					gnd_s[j] <= gneg_s6;
					d1d_s[j] <= d1_s6;
					d2d_s[j] <= d2_s6;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vd_s[j] <= 1'b0;
				end else if (en) begin
					vd_s[j] <= vd_s[j-1];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					gnd_s[j] <= gnd_s[j-1];
					d1d_s[j] <= d1d_s[j-1];
					d2d_s[j] <= d2d_s[j-1];
				end
			end
		end
	end

	// ------------------------------------------------------------ coefficient products
	function automatic logic [44:0] sat_mag(input logic [47:0] v);
		logic [44:0] r;
		r = (v > 48'(hesq_pkg::FACTOR_MAX)) ? hesq_pkg::FACTOR_MAX : v[44:0];
		return r;
	endfunction

	logic [44:0]        gm [4];
	logic               gn [4];
	logic [31:0]        cm [4];
	logic signed [47:0] d1neg;

	assign d1neg = -d1d_s[QW];

	always_comb begin
		gm[0] = sat_mag(48'(q1));
		gn[0] = gnd_s[QW];
		gm[1] = sat_mag(48'(q2));
		gn[1] = 1'b0;
		gm[2] = sat_mag(d1d_s[QW][47] ? d1neg : d1d_s[QW]);
		gn[2] = d1d_s[QW][47];
		gm[3] = sat_mag(48'(d2d_s[QW]));
		gn[3] = 1'b0;
		// coefficient magnitudes
		for (int l = 0; l < 4; l++) begin
			cm[l] = cf_q[LANE_COEF[l]][31] ? (32'd0 - cf_q[LANE_COEF[l]])
			                               : cf_q[LANE_COEF[l]];
		end
	end

	logic        v_s7;
	logic [46:0] ph_s7 [4];
	logic [61:0] pl_s7 [4];
	logic        sg_s7 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= vd_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				ph_s7[l] <= 47'(cm[l]) * 47'(gm[l][44:30]);
				pl_s7[l] <= 62'(cm[l]) * 62'(gm[l][29:0]);
				sg_s7[l] <= cf_q[LANE_COEF[l]][31] ^ gn[l];
			end
		end
	end

	logic               v_s8;
	logic signed [47:0] term_s8 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				term_s8[l] <= sg_s7[l] ? -$signed({1'b0, ph_s7[l] + {15'd0, pl_s7[l][61:30]}})
				                       : $signed({1'b0, ph_s7[l] + {15'd0, pl_s7[l][61:30]}});
			end
		end
	end

	logic               v_s9;
	logic signed [48:0] ec_s9;
	logic signed [48:0] ed_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ec_s9 <= 49'($signed(cf_q[hesq_pkg::REG_CROSS_BASE])) + 49'(term_s8[0])
			         + 49'(term_s8[1]);
			ed_s9 <= 49'($signed(cf_q[hesq_pkg::REG_DIP_BASE])) + 49'(term_s8[2])
			         + 49'(term_s8[3]);
		end
	end

	// ------------------------------------------------------------ clamp and output
	function automatic logic [32:0] clamp_err(input logic signed [48:0] e);
		logic [32:0] r;
		if (e < ERR_MIN) begin
			r = {hesq_pkg::CLAMP_MIN, ERR_MIN[30:0]};
		end else if (e > ERR_MAX) begin
			r = {hesq_pkg::CLAMP_MAX, ERR_MAX[30:0]};
		end else begin
			r = {hesq_pkg::CLAMP_NONE, e[30:0]};
		end
		return r;
	endfunction

	logic [32:0] cl_c;
	logic [32:0] cl_d;

	assign cl_c = clamp_err(ec_s9);
	assign cl_d = clamp_err(ed_s9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q.cross_error_sq <= cl_c[30:0];
			out_data_q.cross_clamp    <= cl_c[32:31];
			out_data_q.dip_error_sq   <= cl_d[30:0];
			out_data_q.dip_clamp      <= cl_d[32:31];
		end
	end

	// ------------------------------------------------------------ assertions
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output hold");
	a_min_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.cross_clamp == hesq_pkg::CLAMP_MIN)
		|-> (out_data.cross_error_sq == ERR_MIN[30:0]))
		else $error("raised cross error is not the minimum");
	a_max_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.dip_clamp == hesq_pkg::CLAMP_MAX)
		|-> (out_data.dip_error_sq == ERR_MAX[30:0]))
		else $error("cut dip error is not the maximum");
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (c2_s6 >= hesq_pkg::C2_MIN))
		else $error("cos squared below floor reaches the dividers");
endmodule
